/* hw/rtl/acr_pkg.sv */
package acr_pkg;

	localparam int MAX_OUT_DEF      = 4096;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// divider runs one quotient bit per cycle over the 72-bit dividend
	localparam int DIV_STEPS = 72;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		OP_SUM   = 3'd0,
		OP_MEAN  = 3'd1,
		OP_COUNT = 3'd2,
		OP_MIN   = 3'd3,
		OP_MAX   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_EMPTY = 2'd1,
		ST_PLANE = 2'd2
	} res_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_COUNT    = 4'd0,
		REG_SIZE_SLOW    = 4'd1,
		REG_SIZE_MID     = 4'd2,
		REG_SIZE_FAST    = 4'd3,
		REG_COLLAPSE_DIM = 4'd4,
		REG_OPERATION    = 4'd5,
		REG_BLANK_VALUE  = 4'd6,
		REG_USE_WEIGHT   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic signed [15:0] weight_value;
	} sample_word_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
		logic [11:0]        out_index;
	} result_word_t;

	typedef struct packed {
		logic signed [63:0] sum;
		logic [15:0]        cnt;
		logic signed [31:0] wsum;
		logic signed [31:0] ext;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic calc;
		logic rd;
		logic upd;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic need_div;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/acr_ctrl.sv */
module acr_ctrl
	import acr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CALC = 6'b000010,
		S_RD   = 6'b000100,
		S_UPD  = 6'b001000,
		S_DIV  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (!sts.last) state_d = S_IDLE;
				else if (sts.need_div) state_d = S_DIV;
				else state_d = S_EMIT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign sample_stall = (state_q != S_IDLE);

endmodule

/* hw/rtl/acr_dp.sv */
module acr_dp
	import acr_pkg::*;
#(
	parameter int MAX_OUT      = MAX_OUT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sample_word_t          sample_word,
	output result_word_t          result_word,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int AW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int SH = 32 - SAMPLE_WIDTH;
	localparam logic [32:0] MAX_OUT_W = 33'(MAX_OUT);
	localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] I64_MIN = {1'b1, {63{1'b0}}};

	// configuration
	logic [1:0]  dim_q, cdim_q;
	logic [15:0] size_slow_q, size_mid_q, size_fast_q;
	logic [2:0]  op_q;
	logic [31:0] blank_q;
	logic        usew_q;
	logic        cfg_hit;

	assign cfg_hit = cfg_valid && (cfg_index <= REG_USE_WEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q       <= 2'd2;
			size_slow_q <= 16'd1;
			size_mid_q  <= 16'd1;
			size_fast_q <= 16'd1;
			cdim_q      <= 2'd0;
			op_q        <= OP_SUM;
			blank_q     <= 32'h8000_0000;
			usew_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIM_COUNT:    dim_q       <= cfg_data[1:0];
				REG_SIZE_SLOW:    size_slow_q <= cfg_data[15:0];
				REG_SIZE_MID:     size_mid_q  <= cfg_data[15:0];
				REG_SIZE_FAST:    size_fast_q <= cfg_data[15:0];
				REG_COLLAPSE_DIM: cdim_q      <= cfg_data[1:0];
				REG_OPERATION:    op_q        <= cfg_data[2:0];
				REG_BLANK_VALUE:  blank_q     <= cfg_data;
				REG_USE_WEIGHT:   usew_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective geometry and operation
	logic [1:0]  nd, cd;
	logic [2:0]  op;
	logic [15:0] s0, s1, s2, sa, sb, sc, ca, cb, cc;
	logic [15:0] c0_q, c1_q, c2_q;
	logic        wmode;

	assign nd = (dim_q == 2'd0) ? 2'd1 : dim_q;
	assign cd = (cdim_q >= nd) ? nd - 2'd1 : cdim_q;
	assign op = (op_q > OP_MAX) ? OP_SUM : op_q;
	assign s0 = (size_slow_q != 16'd0) ? size_slow_q : 16'd1;
	assign s1 = (nd >= 2'd2 && size_mid_q != 16'd0) ? size_mid_q : 16'd1;
	assign s2 = (nd == 2'd3 && size_fast_q != 16'd0) ? size_fast_q : 16'd1;
	assign wmode = usew_q && (op == OP_SUM || op == OP_MEAN);

	always_comb begin
		case (cd)
			2'd0: begin
				sa = s1; sb = s2; sc = s0; ca = c1_q; cb = c2_q; cc = c0_q;
			end
			2'd1: begin
				sa = s0; sb = s2; sc = s1; ca = c0_q; cb = c2_q; cc = c1_q;
			end
			default: begin
				sa = s0; sb = s1; sc = s2; ca = c0_q; cb = c1_q; cc = c2_q;
			end
		endcase
	end

	// input latch
	logic signed [31:0] smp_q, smp_sh;
	logic signed [15:0] wgt_q;
	logic               blank_q2;

	assign smp_sh = $signed(sample_word.sample << SH);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			smp_q    <= smp_sh >>> SH;
			wgt_q    <= sample_word.weight_value;
			blank_q2 <= (((sample_word.sample ^ blank_q) << SH) == 32'd0);
		end
	end

	// index, position flags, product
	logic [31:0]        idx_q;
	logic               bad_q, first_q, last_q;
	logic signed [63:0] prod_q;
	logic signed [47:0] mul;
	logic [31:0]        idx_c, plane_c;

	assign mul     = smp_q * wgt_q;
	assign idx_c   = (32'(ca) * 32'(sb)) + 32'(cb);
	assign plane_c = 32'(sa) * 32'(sb);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			idx_q   <= idx_c;
			bad_q   <= ({1'b0, plane_c} > MAX_OUT_W) || ({1'b0, idx_c} >= MAX_OUT_W);
			first_q <= (cc == 16'd0);
			last_q  <= ({1'b0, cc} + 17'd1) >= {1'b0, sc};
			prod_q  <= wmode ? {{16{mul[47]}}, mul} : {{24{smp_q[31]}}, smp_q, 8'd0};
		end
	end

	// row-major position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
		end else if (cfg_hit) begin
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
		end else if (cmd.calc) begin
			if ({1'b0, c2_q} + 17'd1 >= {1'b0, s2}) begin
				c2_q <= '0;
				if ({1'b0, c1_q} + 17'd1 >= {1'b0, s1}) begin
					c1_q <= '0;
					c0_q <= ({1'b0, c0_q} + 17'd1 >= {1'b0, s0}) ? 16'd0 : c0_q + 16'd1;
				end else begin
					c1_q <= c1_q + 16'd1;
				end
			end else begin
				c2_q <= c2_q + 16'd1;
			end
		end
	end

	// accumulator store
	entry_t mem [MAX_OUT];
	entry_t rd_q, base, nw, entry_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) rd_q <= mem[idx_q[AW-1:0]];
		if (cmd.upd && !bad_q) mem[idx_q[AW-1:0]] <= nw;
	end

	function automatic logic signed [63:0] sat_add64(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] t;
		t = {a[63], a} + {b[63], b};
		if (t[64] != t[63]) return t[64] ? I64_MIN : I64_MAX;
		return t[63:0];
	endfunction

	logic signed [32:0] ws_t;

	always_comb begin
		base = first_q ? '0 : rd_q;
		nw   = base;
		ws_t = {base.wsum[31], base.wsum} + {{17{wgt_q[15]}}, wgt_q};
		if (!blank_q2) begin
			nw.sum = sat_add64(base.sum, prod_q);
			if (wmode) begin
				if (ws_t[32] != ws_t[31]) nw.wsum = ws_t[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				else nw.wsum = ws_t[31:0];
			end
			if (base.cnt == 16'd0 || (op == OP_MIN && smp_q < base.ext) ||
			    (op == OP_MAX && smp_q > base.ext))
				nw.ext = smp_q;
			if (base.cnt != 16'hFFFF) nw.cnt = base.cnt + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) entry_q <= nw;
	end

	assign sts.last     = last_q;
	assign sts.need_div = last_q && !bad_q && op == OP_MEAN && nw.cnt != 16'd0 &&
	                      !(usew_q && nw.wsum == 32'sd0);

	// bit-serial restoring divider for the mean
	logic [71:0]       dvd_q;
	logic [31:0]       dsr_q, rem_q;
	logic              neg_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [63:0]       pmag;
	logic [31:0]       wmag;
	logic [32:0]       trial;
	logic              qbit;

	assign pmag  = nw.sum[63] ? 64'(-nw.sum) : 64'(nw.sum);
	assign wmag  = nw.wsum[31] ? 32'(-nw.wsum) : 32'(nw.wsum);
	assign trial = {rem_q, dvd_q[71]};
	assign qbit  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			dvd_q  <= usew_q ? {pmag, 8'd0} : {8'd0, pmag};
			dsr_q  <= usew_q ? wmag : {16'd0, nw.cnt};
			neg_q  <= usew_q ? (nw.sum[63] ^ nw.wsum[31]) : nw.sum[63];
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[70:0], qbit};
			rem_q  <= qbit ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	assign sts.div_done = (dcnt_q == DCNT_W'(DIV_STEPS - 1));

	// result formation, ties rounded away from zero
	logic [72:0]        mag;
	logic signed [63:0] mean_v;
	result_word_t       res_c, res_q;
	logic               res_v_q;

	assign mag = {1'b0, dvd_q} + 73'({rem_q, 1'b0} >= {1'b0, dsr_q});

	always_comb begin
		if (mag > 73'(I64_MAX)) mean_v = neg_q ? I64_MIN : I64_MAX;
		else mean_v = neg_q ? -$signed(mag[63:0]) : $signed(mag[63:0]);
	end

	always_comb begin
		res_c.out_index = idx_q[11:0];
		res_c.status    = ST_VALID;
		res_c.value     = '0;
		if (bad_q) begin
			res_c.status = ST_PLANE;
		end else if (op == OP_COUNT) begin
			res_c.value = {48'd0, entry_q.cnt};
		end else if (entry_q.cnt == 16'd0) begin
			res_c.status = ST_EMPTY;
		end else begin
			case (op)
				OP_SUM: res_c.value = entry_q.sum;
				OP_MEAN: begin
					if (usew_q && entry_q.wsum == 32'sd0) res_c.status = ST_EMPTY;
					else res_c.value = mean_v;
				end
				default: res_c.value = {{32{entry_q.ext[31]}}, entry_q.ext};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (cmd.emit) res_v_q <= 1'b1;
		else if (!result_stall) res_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res_c;
	end

	assign sts.out_free = !res_v_q || !result_stall;
	assign result_valid = res_v_q;
	assign result_word  = res_q;

endmodule

/* hw/rtl/array_axis_collapse_reducer.sv */
// streaming axis-collapse reducer: samples of a 1-3 dimensional dataset arrive in row-major
// order and are reduced along one configured dimension by sum, mean, count, minimum or
// maximum, with optional q8.8 weights for sum and mean and blank samples skipped. each sample
// passes through accept, index, store read and store update in turn because the accumulator
// store is one read-modify-write memory; a sample that closes an output position then loads
// the result word, waiting while an earlier word still waits in the result register, and a
// mean runs the bit-serial divider before that. the result register lets the next sample in
// while a result word still waits to be taken.
module array_axis_collapse_reducer
	import acr_pkg::*;
#(
	parameter int MAX_OUT      = MAX_OUT_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample channel
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_word_t          sample_word,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_word_t          result_word,
	// register writes, always taken
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: one sample at a time through index, read, update, divide, emit
	acr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// registers, counters, accumulator store, divider and result register
	acr_dp #(
		.MAX_OUT      (MAX_OUT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_word  (sample_word),
		.result_word  (result_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts)
	);

	// writes are never held off and land in their register in the following cycle
	assign cfg_ready = 1'b1;

endmodule

/* hw/rtl/acr_checker.sv */
module acr_checker
	import acr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  sample_valid,
	input logic                  sample_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input result_word_t          result_word
);

	// a stalled result word stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped under stall");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_word))
		else $error("stalled result word changed");

	// one sample in flight: busy right after a take
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("second sample taken while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status != ST_VALID |-> result_word.value == 64'sd0)
		else $error("flagged result carries a value");

endmodule

bind array_axis_collapse_reducer acr_checker u_acr_checker (.*);

/* test/array_axis_collapse_reducer_tb.sv */
`timescale 1ns / 100ps

module array_axis_collapse_reducer_tb;
	import acr_pkg::*;

	localparam int  STORE_DEPTH = 4096;
	localparam int  SETTLE      = 120;     // covers index, store access and the mean divider
	localparam longint CYCLE_LIMIT = 3000000;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	sample_word_t          sample_word;
	logic                  result_valid;
	logic                  result_stall;
	result_word_t          result_word;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	array_axis_collapse_reducer uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample_word(sample_word),
		.result_valid(result_valid), .result_stall(result_stall), .result_word(result_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the register file
	logic [1:0]  sh_dims;
	logic [15:0] sh_len [3];
	logic [1:0]  sh_axis;
	logic [2:0]  sh_op;
	logic [31:0] sh_blank;
	logic        sh_weighted;

	// shadow dataset position and accumulator store
	int unsigned pos [3];
	longint      acc_total  [STORE_DEPTH];
	int unsigned acc_hits   [STORE_DEPTH];
	int          acc_wtotal [STORE_DEPTH];
	int          acc_peak   [STORE_DEPTH];

	result_word_t pending_results [$];

	int     fail_count  = 0;
	longint cycle_count = 0;
	int     sender_gap_pct;
	int     stall_pct;
	int     hold_len  = 0;
	int     hold_seq  = 0;
	int     hold_seen;
	int     hold_left;

	// clock and cycle watchdog
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    <= 0;
			hold_seen    <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen    <= hold_seq;
			hold_left    <= hold_len;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// checker: every taken result word against the oldest expectation
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: index %0d", result_word.out_index);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_word.value !== want.value) begin
					$error("value: expected %0d, actual %0d", want.value, result_word.value);
					fail_count++;
				end
				if (result_word.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result_word.status);
					fail_count++;
				end
				if (result_word.out_index !== want.out_index) begin
					$error("out_index: expected %0d, actual %0d", want.out_index,
						result_word.out_index);
					fail_count++;
				end
			end
		end
	end

	function automatic longint add_clamped(longint a, longint b);
		longint lim_hi;
		longint lim_lo;
		lim_hi = 64'sh7fffffffffffffff;
		lim_lo = 64'sh8000000000000000;
		if (b > 0 && a > lim_hi - b) return lim_hi;
		if (b < 0 && a < lim_lo - b) return lim_lo;
		return a + b;
	endfunction

	function automatic longint unsigned abs_mag(longint a);
		return (a < 0) ? 64'd0 - longint'(unsigned'(a)) : longint'(unsigned'(a));
	endfunction

	// round(n * scale / d), ties away from zero, saturating
	function automatic longint unsigned scaled_quotient(longint unsigned n,
		longint unsigned d, longint unsigned scale);
		longint unsigned q;
		longint unsigned r;
		longint unsigned lo;
		q = n / d;
		r = n % d;
		if (q > 64'hffffffffffffffff / scale) return 64'hffffffffffffffff;
		q = q * scale;
		lo = (r * scale + d / 2) / d;
		if (q > 64'hffffffffffffffff - lo) return 64'hffffffffffffffff;
		return q + lo;
	endfunction

	function automatic longint apply_sign(longint unsigned m, bit neg);
		if (neg) begin
			if (m == 0) return 0;
			if (m > 64'h7fffffffffffffff) return 64'sh8000000000000000;
			return -longint'(m);
		end
		if (m > 64'h7fffffffffffffff) return 64'sh7fffffffffffffff;
		return longint'(m);
	endfunction

	// works out the result word (if any) that one sample word causes
	task automatic reduce_sample(input sample_word_t w);
		int unsigned   ndim;
		int unsigned   axis;
		op_t           op;
		int unsigned   len [3];
		longint unsigned idx;
		longint unsigned plane;
		logic [1:0]    stat;
		longint        val;
		longint        smp;
		longint        wgt;
		longint        ws;
		bit            is_first;
		bit            is_last;
		bit            weighted;
		int unsigned   e;
		result_word_t  r;
		ndim  = (sh_dims == 0) ? 1 : sh_dims;
		axis  = (sh_axis >= ndim) ? ndim - 1 : sh_axis;
		op    = (sh_op > OP_MAX) ? OP_SUM : op_t'(sh_op);
		smp   = longint'(w.sample);
		wgt   = longint'(w.weight_value);
		len[0] = (sh_len[0] != 0) ? sh_len[0] : 1;
		len[1] = (ndim >= 2 && sh_len[1] != 0) ? sh_len[1] : 1;
		len[2] = (ndim == 3 && sh_len[2] != 0) ? sh_len[2] : 1;
		idx   = 0;
		plane = 1;
		stat  = ST_VALID;
		val   = 0;
		for (int d = 0; d < 3; d++)
			if (d != axis) begin
				idx   = idx * len[d] + pos[d];
				plane = plane * len[d];
			end
		is_first = (pos[axis] == 0);
		is_last  = (pos[axis] + 1 >= len[axis]);
		if (plane > STORE_DEPTH || idx >= STORE_DEPTH) begin
			stat = ST_PLANE;
		end else begin
			e = idx[31:0];
			if (is_first) begin
				acc_total[e] = 0; acc_hits[e] = 0; acc_wtotal[e] = 0; acc_peak[e] = 0;
			end
			// blank samples leave the entry alone
			if (w.sample !== sh_blank) begin
				weighted = sh_weighted && (op == OP_SUM || op == OP_MEAN);
				acc_total[e] = add_clamped(acc_total[e], weighted ? smp * wgt : smp * 256);
				if (weighted) begin
					ws = longint'(acc_wtotal[e]) + wgt;
					if (ws > 64'sh7fffffff) ws = 64'sh7fffffff;
					if (ws < -64'sh80000000) ws = -64'sh80000000;
					acc_wtotal[e] = int'(ws);
				end
				if (acc_hits[e] == 0 || (op == OP_MIN && smp < acc_peak[e]) ||
					(op == OP_MAX && smp > acc_peak[e]))
					acc_peak[e] = int'(smp);
				if (acc_hits[e] < 32'hffff) acc_hits[e]++;
			end
			if (is_last) begin
				if (op == OP_COUNT) val = acc_hits[e];
				else if (acc_hits[e] == 0) stat = ST_EMPTY;
				else if (op == OP_SUM) val = acc_total[e];
				else if (op == OP_MEAN) begin
					if (sh_weighted) begin
						// zero weight sum counts as empty
						if (acc_wtotal[e] == 0) stat = ST_EMPTY;
						else val = apply_sign(scaled_quotient(abs_mag(acc_total[e]),
							abs_mag(acc_wtotal[e]), 256),
							(acc_total[e] < 0) != (acc_wtotal[e] < 0));
					end else begin
						val = apply_sign(scaled_quotient(abs_mag(acc_total[e]),
							acc_hits[e], 1), acc_total[e] < 0);
					end
				end else val = acc_peak[e];
			end
		end
		// row-major advance of the dataset position
		pos[2]++;
		if (pos[2] >= len[2]) begin
			pos[2] = 0; pos[1]++;
			if (pos[1] >= len[1]) begin
				pos[1] = 0; pos[0]++;
				if (pos[0] >= len[0]) pos[0] = 0;
			end
		end
		if (is_last) begin
			r.value     = (stat == ST_VALID) ? val : 64'sd0;
			r.status    = stat;
			r.out_index = idx[11:0];
			pending_results.push_back(r);
		end
	endtask

	// offers one word, with a random gap first, and waits until it is taken
	task automatic send_sample(input logic [31:0] smp, input logic [15:0] wgt);
		sample_word_t w;
		int gap;
		w.sample       = smp;
		w.weight_value = wgt;
		gap = 0;
		if ($urandom_range(99) < sender_gap_pct) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		do @(posedge clk); while (sample_stall);
		reduce_sample(w);
	endtask

	// waits for every expected word, then lets the block settle
	task automatic drain;
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_DIM_COUNT:    sh_dims     = data[1:0];
			REG_SIZE_SLOW:    sh_len[0]   = data[15:0];
			REG_SIZE_MID:     sh_len[1]   = data[15:0];
			REG_SIZE_FAST:    sh_len[2]   = data[15:0];
			REG_COLLAPSE_DIM: sh_axis     = data[1:0];
			REG_OPERATION:    sh_op       = data[2:0];
			REG_BLANK_VALUE:  sh_blank    = data;
			REG_USE_WEIGHT:   sh_weighted = data[0];
			default: ;
		endcase
		// any write restarts the dataset
		pos[0] = 0; pos[1] = 0; pos[2] = 0;
	endtask

	task automatic configure(input int dims, input int s0, input int s1, input int s2,
		input int axis, input int op, input logic [31:0] blank, input bit weighted);
		drain();
		write_reg(REG_DIM_COUNT, dims);
		write_reg(REG_SIZE_SLOW, s0);
		write_reg(REG_SIZE_MID, s1);
		write_reg(REG_SIZE_FAST, s2);
		write_reg(REG_COLLAPSE_DIM, axis);
		write_reg(REG_OPERATION, op);
		write_reg(REG_BLANK_VALUE, blank);
		write_reg(REG_USE_WEIGHT, 32'(weighted));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// reset values: 2-d, all lengths 1, so every word closes a position
	task automatic test_reset_state;
		send_sample(32'h7fffffff, 16'h7fff);
		send_sample(32'h80000000, 16'h8000);   // equals the reset blank, empty result
		send_sample(32'hffffffff, 16'h0000);
		send_sample(32'h00000000, 16'hffff);
	endtask

	// every operation code, including the unknown ones, weighted and not
	task automatic test_operations;
		for (int op = 0; op < 8; op++)
			for (int wt = 0; wt < 2; wt++) begin
				configure(2, 3, 2, 1, 0, op, 32'd7, wt != 0);
				send_sample(32'h7fffffff, 16'h7fff);
				send_sample(32'h80000000, 16'h8000);
				send_sample(32'd7, 16'h0100);          // blank
				send_sample(-32'sd5, 16'h0180);
				send_sample(32'd7, 16'h0100);          // blank: column 0 ends with one sample of data
				send_sample(32'd7, 16'h0080);
			end
	endtask

	task automatic test_special_cases;
		// weighted mean whose weights cancel
		configure(1, 2, 1, 1, 0, OP_MEAN, 32'h80000000, 1'b1);
		send_sample(32'd100, 16'h0100);
		send_sample(32'd50, 16'hff00);
		// output plane larger than the store, largest lengths
		configure(2, 65535, 1, 1, 1, OP_SUM, 32'h7fffffff, 1'b0);
		repeat (6) send_sample($urandom, 16'($urandom));
		configure(3, 65535, 65535, 2, 2, OP_MAX, 32'h0, 1'b0);
		repeat (4) send_sample($urandom, 16'($urandom));
		// zero dimension count, zero lengths, collapse index out of range
		configure(0, 3, 0, 0, 3, OP_MIN, 32'h80000000, 1'b0);
		repeat (6) send_sample($urandom_range(20), 16'd0);
		configure(3, 0, 2, 0, 3, OP_COUNT, 32'd1, 1'b1);
		repeat (4) send_sample($urandom_range(2), 16'd0);
	endtask

	// receiver holds off while the sender keeps pushing
	task automatic test_backpressure;
		configure(2, 4, 1, 1, 1, OP_SUM, 32'h80000000, 1'b0);
		sender_gap_pct = 0;
		stall_pct      = 0;
		hold_len       = 400;
		hold_seq++;
		repeat (30) send_sample($urandom, 16'($urandom));
	endtask

	task automatic test_random_datasets;
		int sent;
		int total;
		int dims;
		int s [3];
		logic [31:0] blank;
		logic [31:0] smp;
		sent = 0;
		while (sent < 400) begin
			// idle pattern moves through three phases
			if (sent < 133) begin sender_gap_pct = 18; stall_pct = 45; end
			else if (sent < 266) begin sender_gap_pct = 45; stall_pct = 18; end
			else begin sender_gap_pct = 0; stall_pct = 0; end
			dims = $urandom_range(3);
			for (int d = 0; d < 3; d++) s[d] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
			blank = ($urandom_range(1)) ? $urandom_range(3) : $urandom;
			configure(dims, s[0], s[1], s[2], $urandom_range(3), $urandom_range(7), blank,
				$urandom_range(1) != 0);
			total = 1;
			for (int d = 0; d < 3; d++) total *= (s[d] == 0) ? 1 : s[d];
			total = total * $urandom_range(1, 2) + $urandom_range(0, 2);
			for (int k = 0; k < total && sent < 400; k++) begin
				case ($urandom_range(9))
					0, 1:    smp = blank;
					2:       smp = $urandom;
					3:       smp = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
					default: smp = $urandom_range(2000) - 1000;
				endcase
				send_sample(smp, ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		sample_word    = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		sender_gap_pct = 18;
		stall_pct      = 45;
		sh_dims = 2; sh_len[0] = 1; sh_len[1] = 1; sh_len[2] = 1;
		sh_axis = 0; sh_op = OP_SUM; sh_blank = 32'h80000000; sh_weighted = 1'b0;
		pos[0] = 0; pos[1] = 0; pos[2] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_operations();
		test_special_cases();
		test_backpressure();
		test_random_datasets();
		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
